>>> hdl/spk_pkg.sv
`default_nettype none
package spk_pkg;

  localparam int WORD_W      = 64;
  localparam int STORE_DEPTH = 32;
  localparam int KIDX_W      = $clog2(STORE_DEPTH);
  localparam int ADDR_W      = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXPAND,
    ST_LOAD,
    ST_ROUND
  } spk_state_t;

  typedef struct packed {
    logic              load_item;
    logic              key_init;
    logic              key_step;
    logic              round_step;
    logic              op;
    logic [KIDX_W-1:0] kaddr;
    logic              done;
  } spk_cmd_t;

endpackage
`default_nettype wire

>>> hdl/speck128_128_block_cipher_unit.sv
`default_nettype none
// Channel   Handshake                 Payload
// input     start / busy              in_op, in_block_word0, in_block_word1
// result    out_valid (strobe)        out_result_word0, out_result_word1
// config    psel/penable/pwrite/pready paddr, pwdata, prdata (keys at 0x0, 0x8)
//
// After acceptance a block first spends a load step on the first round key read,
// then runs one round per cycle through the single round unit, fed from the
// registered read port of the round key store.
// The first block after reset or a key write first expands the round keys,
// one key written to the store per cycle.
// Reset clears the key registers and marks the round keys stale; busy stays high
// until the result is shown, and the result lasts one cycle with no stall.
module speck128_128_block_cipher_unit #(
  parameter int ROUNDS = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic                         in_op,
  input  wire logic [spk_pkg::WORD_W-1:0]   in_block_word0,
  input  wire logic [spk_pkg::WORD_W-1:0]   in_block_word1,
  output logic                              out_valid,
  output logic [spk_pkg::WORD_W-1:0]        out_result_word0,
  output logic [spk_pkg::WORD_W-1:0]        out_result_word1,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [spk_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [spk_pkg::WORD_W-1:0]   pwdata,
  output logic [spk_pkg::WORD_W-1:0]        prdata,
  output logic                              pready
);
  import spk_pkg::*;

  logic [WORD_W-1:0] key_word0_r;
  logic [WORD_W-1:0] key_word1_r;
  logic              key_write;
  spk_cmd_t          cmd;

  assign pready    = 1'b1;
  assign key_write = psel && penable && pwrite && pready;
  assign prdata    = paddr[3] ? key_word1_r : key_word0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_word0_r <= '0;
      key_word1_r <= '0;
    end else if (key_write) begin
      if (paddr[3]) begin
        key_word1_r <= pwdata;
      end else begin
        key_word0_r <= pwdata;
      end
    end
  end

  spk_ctrl #(
    .ROUNDS(ROUNDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_op    (in_op),
    .key_write(key_write),
    .busy     (busy),
    .cmd      (cmd)
  );

  spk_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .key_word0(key_word0_r),
    .key_word1(key_word1_r),
    .in_word0 (in_block_word0),
    .in_word1 (in_block_word1),
    .out_valid(out_valid),
    .out_word0(out_result_word0),
    .out_word1(out_result_word1)
  );

  a_result_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while still busy");

  a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the unit busy");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_no_strobe_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> !out_valid)
    else $error("result strobe right after acceptance");

endmodule
`default_nettype wire

>>> hdl/spk_ctrl.sv
`default_nettype none
module spk_ctrl #(
  parameter int ROUNDS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic              in_op,
  input  wire logic              key_write,
  output logic                   busy,
  output spk_pkg::spk_cmd_t      cmd
);
  import spk_pkg::*;

  localparam logic [KIDX_W-1:0] LAST = KIDX_W'(ROUNDS - 1);

  spk_state_t        state_r, state_nxt;
  logic [KIDX_W-1:0] cnt_r, cnt_nxt;
  logic              op_r, op_nxt;
  logic              keys_ready_r, keys_ready_nxt;
  logic [KIDX_W-1:0] step_idx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      op_r         <= 1'b0;
      keys_ready_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      op_r         <= op_nxt;
      keys_ready_r <= keys_ready_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    op_nxt         = op_r;
    keys_ready_nxt = keys_ready_r && !key_write;
    busy           = 1'b1;
    step_idx       = '0;
    cmd            = '0;
    cmd.op         = op_r;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load_item = 1'b1;
          op_nxt        = in_op;
          cnt_nxt       = '0;
          if (keys_ready_r) begin
            state_nxt = ST_LOAD;
          end else begin
            cmd.key_init = 1'b1;
            state_nxt    = ST_EXPAND;
          end
        end
      end
      ST_EXPAND: begin
        cmd.key_step = 1'b1;
        cmd.kaddr    = cnt_r;
        if (cnt_r == LAST) begin
          keys_ready_nxt = 1'b1;
          cnt_nxt        = '0;
          state_nxt      = ST_LOAD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_LOAD: begin
        step_idx  = '0;
        cmd.kaddr = op_r ? (LAST - step_idx) : step_idx;
        state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_step = 1'b1;
        step_idx       = cnt_r + 1'b1;
        cmd.kaddr      = op_r ? (LAST - step_idx) : step_idx;
        if (cnt_r == LAST) begin
          cmd.done  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hdl/spk_dp.sv
`default_nettype none
module spk_dp (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire spk_pkg::spk_cmd_t           cmd,
  input  wire logic [spk_pkg::WORD_W-1:0]  key_word0,
  input  wire logic [spk_pkg::WORD_W-1:0]  key_word1,
  input  wire logic [spk_pkg::WORD_W-1:0]  in_word0,
  input  wire logic [spk_pkg::WORD_W-1:0]  in_word1,
  output logic                             out_valid,
  output logic [spk_pkg::WORD_W-1:0]       out_word0,
  output logic [spk_pkg::WORD_W-1:0]       out_word1
);
  import spk_pkg::*;

  logic [WORD_W-1:0] rk_mem [STORE_DEPTH];
  logic [WORD_W-1:0] rk_rd_r;
  logic [WORD_W-1:0] sched_r, sched_nxt;
  logic [WORD_W-1:0] rk_r, rk_nxt;
  logic [WORD_W-1:0] x_r, x_nxt;
  logic [WORD_W-1:0] y_r, y_nxt;
  logic [WORD_W-1:0] enc_x, enc_y, dec_x, dec_y, dec_t;
  logic              valid_r;

  always_ff @(posedge clk) begin
    if (cmd.key_step) begin
      rk_mem[cmd.kaddr] <= rk_r;
    end
    rk_rd_r <= rk_mem[cmd.kaddr];
  end

  always_comb begin
    sched_nxt = (rk_r + {sched_r[7:0], sched_r[WORD_W-1:8]})
                ^ {{(WORD_W-KIDX_W){1'b0}}, cmd.kaddr};
    rk_nxt    = {rk_r[WORD_W-4:0], rk_r[WORD_W-1:WORD_W-3]} ^ sched_nxt;
  end

  always_comb begin
    enc_x = ({x_r[7:0], x_r[WORD_W-1:8]} + y_r) ^ rk_rd_r;
    enc_y = {y_r[WORD_W-4:0], y_r[WORD_W-1:WORD_W-3]} ^ enc_x;
    dec_t = x_r ^ y_r;
    dec_y = {dec_t[2:0], dec_t[WORD_W-1:3]};
    dec_t = (x_r ^ rk_rd_r) - dec_y;
    dec_x = {dec_t[WORD_W-9:0], dec_t[WORD_W-1:WORD_W-8]};
  end

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    priority if (cmd.load_item) begin
      x_nxt = in_word0;
      y_nxt = in_word1;
    end else if (cmd.round_step) begin
      x_nxt = cmd.op ? dec_x : enc_x;
      y_nxt = cmd.op ? dec_y : enc_y;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
    if (cmd.key_init) begin
      sched_r <= key_word0;
      rk_r    <= key_word1;
    end else if (cmd.key_step) begin
      sched_r <= sched_nxt;
      rk_r    <= rk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= cmd.done;
    end
  end

  assign out_valid = valid_r;
  assign out_word0 = x_r;
  assign out_word1 = y_r;

endmodule
`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int ROUNDS        = 32;
  localparam int KEY_WORD0_IDX = 0;
  localparam int KEY_WORD1_IDX = 1;
  localparam logic OP_ENCRYPT  = 1'b0;
  localparam logic OP_DECRYPT  = 1'b1;
  localparam int STALL_LIMIT   = 2000;
  localparam int MAX_GAP       = 40;

  class speck_predictor;
    typedef struct packed {
      logic [63:0] w0;
      logic [63:0] w1;
    } block_pair_t;

    logic [63:0] key_word [2];
    logic [63:0] round_keys [ROUNDS];
    bit          keys_fresh;
    block_pair_t pending_blocks [$];
    int          mismatches;
    int          strays;

    function new();
      key_word[0] = '0;
      key_word[1] = '0;
      keys_fresh  = 1'b0;
      mismatches  = 0;
      strays      = 0;
    endfunction

    static function logic [63:0] ror(logic [63:0] v, int r);
      return (v >> r) | (v << (64 - r));
    endfunction

    static function logic [63:0] rol(logic [63:0] v, int r);
      return (v << r) | (v >> (64 - r));
    endfunction

    function void write_key(int idx, logic [63:0] value);
      if (idx == KEY_WORD0_IDX || idx == KEY_WORD1_IDX) begin
        key_word[idx] = value;
        keys_fresh    = 1'b0;
      end
    endfunction

    function void expand_keys();
      logic [63:0] sched;
      logic [63:0] rkey;
      sched         = key_word[KEY_WORD0_IDX];
      rkey          = key_word[KEY_WORD1_IDX];
      round_keys[0] = rkey;
      for (int i = 0; i < ROUNDS - 1; i++) begin
        sched             = (rkey + ror(sched, 8)) ^ 64'(i);
        rkey              = rol(rkey, 3) ^ sched;
        round_keys[i + 1] = rkey;
      end
      keys_fresh = 1'b1;
    endfunction

    function void note_block(logic op, logic [63:0] x_in, logic [63:0] y_in);
      logic [63:0] x;
      logic [63:0] y;
      x = x_in;
      y = y_in;
      if (!keys_fresh) expand_keys();
      if (op == OP_ENCRYPT) begin
        for (int i = 0; i < ROUNDS; i++) begin
          x = (ror(x, 8) + y) ^ round_keys[i];
          y = rol(y, 3) ^ x;
        end
      end else begin
        for (int i = 0; i < ROUNDS; i++) begin
          y = ror(x ^ y, 3);
          x = rol((x ^ round_keys[ROUNDS - 1 - i]) - y, 8);
        end
      end
      pending_blocks.push_back('{w0: x, w1: y});
    endfunction

    function void check_block(logic [63:0] w0, logic [63:0] w1);
      block_pair_t want;
      if (pending_blocks.size() == 0) begin
        strays++;
        $display("%0t: unexpected result word %h %h", $time, w0, w1);
        return;
      end
      want = pending_blocks.pop_front();
      if (w0 !== want.w0) begin
        mismatches++;
        $display("%0t: result_word0 expected %h actual %h", $time, want.w0, w0);
      end
      if (w1 !== want.w1) begin
        mismatches++;
        $display("%0t: result_word1 expected %h actual %h", $time, want.w1, w1);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic                          in_op;
  logic [spk_pkg::WORD_W-1:0]    in_block_word0;
  logic [spk_pkg::WORD_W-1:0]    in_block_word1;
  logic                          out_valid;
  logic [spk_pkg::WORD_W-1:0]    out_result_word0;
  logic [spk_pkg::WORD_W-1:0]    out_result_word1;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [spk_pkg::ADDR_W-1:0]    paddr;
  logic [spk_pkg::WORD_W-1:0]    pwdata;
  logic [spk_pkg::WORD_W-1:0]    prdata;
  logic                          pready;

  speck_predictor predictor;
  int gap_pct;
  int encrypt_count;
  int decrypt_count;
  int key_write_count;
  int quiet_cycles;

  speck128_128_block_cipher_unit #(.ROUNDS(ROUNDS)) DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_block_word0   (in_block_word0),
    .in_block_word1   (in_block_word1),
    .out_valid        (out_valid),
    .out_result_word0 (out_result_word0),
    .out_result_word1 (out_result_word1),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      predictor.check_block(out_result_word0, out_result_word1);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && busy === 1'b0) || out_valid === 1'b1 || (psel && penable && pwrite)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
        $display("testbench failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [63:0] pick_block_word();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(63);
      3:       return ~(64'd1 << $urandom_range(63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic send_block(input logic op, input logic [63:0] x, input logic [63:0] y);
    if ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, MAX_GAP)) @(posedge clk);
    end
    start          <= 1'b1;
    in_op          <= op;
    in_block_word0 <= x;
    in_block_word1 <= y;
    do @(posedge clk); while (busy !== 1'b0);
    predictor.note_block(op, x, y);
    if (op == OP_ENCRYPT) encrypt_count++;
    else decrypt_count++;
  endtask

  task automatic write_key(input int idx, input logic [63:0] value);
    start <= 1'b0;
    do @(posedge clk); while (predictor.pending_blocks.size() != 0 || busy !== 1'b0);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= spk_pkg::ADDR_W'(idx * 8);
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    predictor.write_key(idx, value);
    key_write_count++;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int fails;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_ENCRYPT;
    in_block_word0 = '0;
    in_block_word1 = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    quiet_cycles   = 0;
    gap_pct        = 0;
    predictor      = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // The first blocks run on the all-zero key left by reset.
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);
    write_key(KEY_WORD0_IDX, 64'h0f0e0d0c0b0a0908);
    write_key(KEY_WORD1_IDX, 64'h0706050403020100);
    send_block(OP_ENCRYPT, 64'h6c61766975716520, 64'h7469206564616d20);
    send_block(OP_DECRYPT, 64'ha65d985179783265, 64'h7860fedf5c570d18);
    send_block(OP_ENCRYPT, '1, '0);
    send_block(OP_ENCRYPT, '0, '1);
    send_block(OP_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
    // Rewriting a single key word must still trigger a fresh expansion.
    write_key(KEY_WORD0_IDX, '1);
    send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);
    send_block(OP_DECRYPT, '0, '0);
    write_key(KEY_WORD1_IDX, '1);
    send_block(OP_ENCRYPT, '1, '1);
    send_block(OP_DECRYPT, '1, '0);
    write_key(KEY_WORD0_IDX, '0);
    write_key(KEY_WORD1_IDX, '0);
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);

    for (int phase = 0; phase < 4; phase++) begin
      gap_pct = (phase == 1) ? 56 : (phase == 3) ? 29 : 0;
      for (int seg = 0; seg < 4; seg++) begin
        case ($urandom_range(3))
          0: begin
            write_key(KEY_WORD0_IDX, pick_block_word());
            write_key(KEY_WORD1_IDX, pick_block_word());
          end
          1: write_key(KEY_WORD0_IDX, {$urandom, $urandom});
          2: write_key(KEY_WORD1_IDX, {$urandom, $urandom});
          default: begin
            write_key(KEY_WORD0_IDX, $urandom_range(1) ? '1 : '0);
            write_key(KEY_WORD1_IDX, $urandom_range(1) ? '1 : '0);
          end
        endcase
        for (int n = 0; n < 60; n++) begin
          send_block(logic'($urandom_range(1)), pick_block_word(), pick_block_word());
        end
      end
    end

    start <= 1'b0;
    while (predictor.pending_blocks.size() != 0) @(posedge clk);
    repeat (MAX_GAP) @(posedge clk);

    fails = predictor.mismatches + predictor.strays + predictor.pending_blocks.size();
    $display("Checked %0d encrypted and %0d decrypted blocks across %0d key register writes,",
             encrypt_count, decrypt_count, key_write_count);
    $display("with back-to-back input and with random idle gaps on the input side.");
    if (fails == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/spk_pkg.sv
hdl/spk_ctrl.sv
hdl/spk_dp.sv
hdl/speck128_128_block_cipher_unit.sv
bench/testbench.sv
